// File: rtl/core/lfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared types, constants and fixed-point helpers of the light culling unit.
// ----------------------------------------------------------------------------
package lfc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int FRAC_BITS   = 16;
    localparam int PIDX_W      = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;

    typedef enum logic [1:0] {
        CMD_LOAD_ROW   = 2'd0,
        CMD_LOAD_PLANE = 2'd1,
        CMD_CULL_POINT = 2'd2,
        CMD_CULL_SPOT  = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE, S_TP, S_TPW, S_TD, S_TDW, S_BR, S_BRW,
        S_PL, S_PLW, S_TIP, S_TIPW, S_DN, S_DNW, S_DD, S_DDW,
        S_CV, S_CVW, S_SQ, S_SQW, S_RT, S_DIV, S_DIVW, S_E1, S_E1W, S_E2W, S_OUT
    } bst_t;

    typedef struct packed {
        logic               spot;
        logic signed [31:0] px, py, pz;
        logic signed [31:0] dx, dy, dz;
        logic        [30:0] len;
        logic        [30:0] tan_half;
    } job_t;

    typedef struct packed {
        logic visible;
        logic light_kind;
    } res_t;

    localparam int JOB_W = $bits(job_t);

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (x < -64'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // floor(p / ONE) of a full 64-bit product
    function automatic logic signed [63:0] qshift(input logic signed [63:0] p);
        return p >>> FRAC_BITS;
    endfunction

endpackage

// File: rtl/core/light_frustum_culling.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_frustum_culling
// Sphere and cone culling against six frustum planes in Q16.16.
// ----------------------------------------------------------------------------
// Usage: s_ channel takes items; tdata = command[1:0], slot[4:2], val_a..val_d,
// dir_x..dir_z, light_radius, tan_half_angle from the low bit up. Commands 0
// and 1 load a matrix row or a plane and give no result; a load is held off
// until no cull job is queued or running. Commands 2 and 3 cull a point or
// spot light and give one m_ item with tdata = {light_kind, visible}.
// A two-entry queue sits between the front and the sequencer, so new jobs are
// taken while a job runs. The sequencer shares one 32x32 multiplier; a spot
// light adds a second transform, the square-root loop and three divisions
// per plane that reaches the edge test. Reset clears the stores to zero and
// empties the queue. When the receiver stalls the result holds in m_tdata and
// the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module light_frustum_culling
    import lfc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [303:0] s_tdata,  // command, slot, val_a..d, dir_x..z, radius, tan
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata   // visible, light_kind
);
    logic signed [31:0] rows   [12];
    logic signed [31:0] planes [PLANE_COUNT*4];
    logic job_valid, job_ready, res_valid;
    job_t job;
    res_t res;

    lfc_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .command(s_tdata[1:0]), .slot(s_tdata[4:2]),
        .val_a(s_tdata[36:5]), .val_b(s_tdata[68:37]),
        .val_c(s_tdata[100:69]), .val_d(s_tdata[132:101]),
        .dir_x(s_tdata[164:133]), .dir_y(s_tdata[196:165]),
        .dir_z(s_tdata[228:197]),
        .light_radius(s_tdata[259:229]), .tan_half_angle(s_tdata[290:260]),
        .rows_o(rows), .planes_o(planes),
        .job_valid, .job_ready, .job_o(job)
    );

    lfc_back u_back (
        .aclk, .aresetn,
        .rows_i(rows), .planes_i(planes),
        .job_valid, .job_ready, .job_i(job),
        .res_valid, .res_ready(m_tready), .res_o(res)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {6'd0, res.light_kind, res.visible};

endmodule

// File: rtl/core/lfc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfc_front
// Accept items, perform matrix/plane loads, queue cull jobs in a two-entry fifo.
// ----------------------------------------------------------------------------
module lfc_front
    import lfc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          command,
    input  logic [2:0]          slot,
    input  logic signed [31:0]  val_a, val_b, val_c, val_d,
    input  logic signed [31:0]  dir_x, dir_y, dir_z,
    input  logic [30:0]         light_radius,
    input  logic [30:0]         tan_half_angle,
    output logic signed [31:0]  rows_o   [12],
    output logic signed [31:0]  planes_o [PLANE_COUNT*4],
    output logic                job_valid,
    input  logic                job_ready,
    output job_t                job_o
);
    job_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       wr_reg, rd_reg;
    logic signed [31:0] rows_reg   [12];
    logic signed [31:0] planes_reg [PLANE_COUNT*4];
    logic       acc, is_cull, push, pop;
    job_t       nj;

    // hold loads until no cull job is queued or running
    assign is_cull   = (command == CMD_CULL_POINT) || (command == CMD_CULL_SPOT);
    assign in_ready  = (cnt_reg != 2'd2) && (is_cull || (cnt_reg == 2'd0 && job_ready));
    assign acc       = in_valid && in_ready;
    assign push      = acc && is_cull;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job_o     = q_reg[rd_reg];
    assign rows_o    = rows_reg;
    assign planes_o  = planes_reg;

    always_comb begin
        nj.spot     = (command == CMD_CULL_SPOT);
        nj.px       = val_a;
        nj.py       = val_b;
        nj.pz       = val_c;
        nj.dx       = dir_x;
        nj.dy       = dir_y;
        nj.dz       = dir_z;
        nj.len      = light_radius;
        nj.tan_half = tan_half_angle;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            for (int i = 0; i < 12; i++) rows_reg[i] <= '0;
            for (int i = 0; i < PLANE_COUNT*4; i++) planes_reg[i] <= '0;
        end else begin
            if (push) begin
                q_reg[wr_reg] <= nj;
                wr_reg        <= ~wr_reg;
            end
            if (pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (acc && command == CMD_LOAD_ROW && slot < 3'd3) begin
                rows_reg[slot*4+0] <= val_a;
                rows_reg[slot*4+1] <= val_b;
                rows_reg[slot*4+2] <= val_c;
                rows_reg[slot*4+3] <= val_d;
            end
            if (acc && command == CMD_LOAD_PLANE && 32'(slot) < PLANE_COUNT) begin
                planes_reg[slot*4+0] <= val_a;
                planes_reg[slot*4+1] <= val_b;
                planes_reg[slot*4+2] <= val_c;
                planes_reg[slot*4+3] <= val_d;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !in_ready) else $error("accept when full");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !job_valid) else $error("job from empty queue");

endmodule

// File: rtl/core/lfc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfc_back
// Sequencer over one shared multiplier, square root and divider: runs the
// camera transform and the per-plane tests of one job, holds the result item.
// ----------------------------------------------------------------------------
module lfc_back
    import lfc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic signed [31:0]  rows_i   [12],
    input  logic signed [31:0]  planes_i [PLANE_COUNT*4],
    input  logic                job_valid,
    output logic                job_ready,
    input  job_t                job_i,
    output logic                res_valid,
    input  logic                res_ready,
    output res_t                res_o
);
    bst_t st_reg;
    job_t job_reg;
    logic [PIDX_W-1:0] pl_reg;
    logic [1:0] k_reg;
    logic [1:0] t_reg;
    logic signed [31:0] p_reg [3], d_reg [3], cen_reg [3], v_reg [3], c_reg [3];
    logic signed [31:0] br_reg, dd_reg, dns_reg;
    logic signed [63:0] acc_reg, tipd_reg, dn_reg;
    logic signed [63:0] prod_reg;
    logic [63:0] sq_reg;
    logic        vis_reg, res_v_reg;
    logic        out_vis_reg, out_kind_reg;
    // multiplier operand registers
    logic signed [31:0] ma_reg, mb_reg;
    logic signed [63:0] mp;
    // isqrt
    logic [63:0] sx_reg, sres_reg, sbit_reg;
    // divider
    logic [63:0] dnum_reg, drem_reg, dquo_reg;
    logic [31:0] dden_reg;
    logic [6:0]  dcnt_reg;
    logic signed [31:0] nrm [3];
    logic signed [31:0] off;

    assign mp = ma_reg * mb_reg;
    assign nrm[0] = planes_i[pl_reg*4+0];
    assign nrm[1] = planes_i[pl_reg*4+1];
    assign nrm[2] = planes_i[pl_reg*4+2];
    assign off    = planes_i[pl_reg*4+3];

    assign job_ready = (st_reg == S_IDLE);
    assign res_valid = res_v_reg;
    assign res_o     = '{visible: out_vis_reg, light_kind: out_kind_reg};

    function automatic logic signed [31:0] vsel(input logic signed [31:0] v [3],
                                                input logic [1:0] k);
        return (k == 2'd0) ? v[0] : ((k == 2'd1) ? v[1] : v[2]);
    endfunction

    logic signed [31:0] wv [3], dv [3];
    logic signed [31:0] vk;
    logic [31:0] vabs;
    logic last_pl;
    assign wv[0] = job_reg.px;
    assign wv[1] = job_reg.py;
    assign wv[2] = job_reg.pz;
    assign dv[0] = job_reg.dx;
    assign dv[1] = job_reg.dy;
    assign dv[2] = job_reg.dz;
    assign last_pl = (32'(pl_reg) == PLANE_COUNT - 1);
    assign vk   = vsel(v_reg, k_reg);
    assign vabs = vk[31] ? 32'(-vk) : vk;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= S_IDLE;
            res_v_reg    <= 1'b0;
            out_vis_reg  <= 1'b0;
            out_kind_reg <= 1'b0;
        end else begin
            unique case (st_reg)
                S_IDLE: if (job_valid) begin
                    job_reg <= job_i;
                    k_reg   <= '0;
                    t_reg   <= '0;
                    acc_reg <= '0;
                    st_reg  <= S_TP;
                end
                // camera position: row k times w, plus translation
                S_TP: begin
                    ma_reg <= rows_i[k_reg*4 + 32'(t_reg)];
                    mb_reg <= vsel(wv, t_reg);
                    st_reg <= S_TPW;
                end
                S_TPW: begin
                    if (t_reg == 2'd2) begin
                        p_reg[k_reg] <= sat32(acc_reg + qshift(mp)
                                              + 64'(rows_i[k_reg*4+3]));
                        acc_reg <= '0;
                        t_reg   <= '0;
                        if (k_reg == 2'd2) begin
                            k_reg  <= '0;
                            st_reg <= job_reg.spot ? S_TD : S_PL;
                            pl_reg <= '0;
                        end else begin
                            k_reg  <= k_reg + 2'd1;
                            st_reg <= S_TP;
                        end
                    end else begin
                        acc_reg <= acc_reg + qshift(mp);
                        t_reg   <= t_reg + 2'd1;
                        st_reg  <= S_TP;
                    end
                end
                S_TD: begin
                    ma_reg <= rows_i[k_reg*4 + 32'(t_reg)];
                    mb_reg <= vsel(dv, t_reg);
                    st_reg <= S_TDW;
                end
                S_TDW: begin
                    if (t_reg == 2'd2) begin
                        d_reg[k_reg] <= sat32(acc_reg + qshift(mp));
                        acc_reg <= '0;
                        t_reg   <= '0;
                        if (k_reg == 2'd2) begin
                            k_reg  <= '0;
                            st_reg <= S_BR;
                        end else begin
                            k_reg  <= k_reg + 2'd1;
                            st_reg <= S_TD;
                        end
                    end else begin
                        acc_reg <= acc_reg + qshift(mp);
                        t_reg   <= t_reg + 2'd1;
                        st_reg  <= S_TD;
                    end
                end
                S_BR: begin
                    ma_reg <= {1'b0, job_reg.len};
                    mb_reg <= {1'b0, job_reg.tan_half};
                    st_reg <= S_BRW;
                end
                S_BRW: begin
                    br_reg <= sat32(qshift(mp));
                    pl_reg <= '0;
                    st_reg <= S_TIP;
                end
                // point light plane test
                S_PL: begin
                    ma_reg <= vsel(p_reg, t_reg);
                    mb_reg <= vsel(nrm, t_reg);
                    st_reg <= S_PLW;
                end
                S_PLW: begin
                    if (t_reg == 2'd2) begin
                        t_reg   <= '0;
                        acc_reg <= '0;
                        if (acc_reg + qshift(mp) - 64'(off)
                            + $signed(64'(job_reg.len)) < 0) begin
                            vis_reg <= 1'b0;
                            st_reg  <= S_OUT;
                        end else if (last_pl) begin
                            vis_reg <= 1'b1;
                            st_reg  <= S_OUT;
                        end else begin
                            pl_reg <= pl_reg + 1'b1;
                            st_reg <= S_PL;
                        end
                    end else begin
                        acc_reg <= acc_reg + qshift(mp);
                        t_reg   <= t_reg + 2'd1;
                        st_reg  <= S_PL;
                    end
                end
                // spot light plane test
                S_TIP: begin
                    ma_reg <= vsel(p_reg, t_reg);
                    mb_reg <= vsel(nrm, t_reg);
                    st_reg <= S_TIPW;
                end
                S_TIPW: begin
                    if (t_reg == 2'd2) begin
                        t_reg    <= '0;
                        acc_reg  <= '0;
                        tipd_reg <= acc_reg + qshift(mp) - 64'(off);
                        if (acc_reg + qshift(mp) - 64'(off) >= 0) st_reg <= S_E2W;
                        else st_reg <= S_DN;
                    end else begin
                        acc_reg <= acc_reg + qshift(mp);
                        t_reg   <= t_reg + 2'd1;
                        st_reg  <= S_TIP;
                    end
                end
                S_DN: begin
                    ma_reg <= vsel(d_reg, t_reg);
                    mb_reg <= vsel(nrm, t_reg);
                    st_reg <= S_DNW;
                end
                S_DNW: begin
                    if (t_reg == 2'd2) begin
                        t_reg   <= '0;
                        acc_reg <= '0;
                        dn_reg  <= acc_reg + qshift(mp);
                        dns_reg <= sat32(acc_reg + qshift(mp));
                        st_reg  <= S_DD;
                    end else begin
                        acc_reg <= acc_reg + qshift(mp);
                        t_reg   <= t_reg + 2'd1;
                        st_reg  <= S_DN;
                    end
                end
                S_DD: begin
                    if (dn_reg == -ONE_Q) begin
                        vis_reg <= 1'b0;
                        st_reg  <= S_OUT;
                    end else if (dn_reg == ONE_Q) begin
                        if (-tipd_reg > $signed(64'(job_reg.len))) begin
                            vis_reg <= 1'b0;
                            st_reg  <= S_OUT;
                        end else st_reg <= S_E2W;
                    end else begin
                        ma_reg <= vsel(d_reg, t_reg);
                        mb_reg <= vsel(d_reg, t_reg);
                        st_reg <= S_DDW;
                    end
                end
                S_DDW: begin
                    if (t_reg == 2'd2) begin
                        t_reg   <= '0;
                        acc_reg <= '0;
                        dd_reg  <= sat32(acc_reg + qshift(mp));
                        k_reg   <= '0;
                        st_reg  <= S_CV;
                    end else begin
                        acc_reg <= acc_reg + qshift(mp);
                        t_reg   <= t_reg + 2'd1;
                        st_reg  <= S_DD;
                    end
                end
                // t 0: d*len, t 1: n*dd, t 2: d*dns
                S_CV: begin
                    ma_reg <= (t_reg == 2'd1) ? vsel(nrm, k_reg) : vsel(d_reg, k_reg);
                    mb_reg <= (t_reg == 2'd0) ? {1'b0, job_reg.len}
                            : ((t_reg == 2'd1) ? dd_reg : dns_reg);
                    st_reg <= S_CVW;
                end
                S_CVW: begin
                    if (t_reg == 2'd0) begin
                        cen_reg[k_reg] <= sat32(64'(vsel(p_reg, k_reg)) + qshift(mp));
                        t_reg  <= 2'd1;
                        st_reg <= S_CV;
                    end else if (t_reg == 2'd1) begin
                        prod_reg <= qshift(mp);
                        t_reg    <= 2'd2;
                        st_reg   <= S_CV;
                    end else begin
                        v_reg[k_reg] <= sat32(prod_reg - qshift(mp));
                        t_reg <= '0;
                        if (k_reg == 2'd2) begin
                            k_reg  <= '0;
                            sq_reg <= '0;
                            st_reg <= S_SQ;
                        end else begin
                            k_reg  <= k_reg + 2'd1;
                            st_reg <= S_CV;
                        end
                    end
                end
                S_SQ: begin
                    ma_reg <= $signed({1'b0, vabs[30:0]});
                    mb_reg <= $signed({1'b0, vabs[30:0]});
                    st_reg <= S_SQW;
                end
                S_SQW: begin
                    // |v| may be 2^31: square is 2^62
                    if (vabs[31]) sq_reg <= sq_reg + (64'd1 << 62);
                    else sq_reg <= sq_reg + $unsigned(mp);
                    if (k_reg == 2'd2) begin
                        k_reg    <= '0;
                        sres_reg <= '0;
                        sbit_reg <= 64'd1 << 62;
                        st_reg   <= S_RT;
                        sx_reg   <= (vabs[31] ? sq_reg + (64'd1 << 62)
                                              : sq_reg + $unsigned(mp));
                    end else begin
                        k_reg  <= k_reg + 2'd1;
                        st_reg <= S_SQ;
                    end
                end
                S_RT: begin
                    if (sbit_reg == '0) begin
                        if (sres_reg == '0) st_reg <= S_E2W;
                        else begin
                            dden_reg <= sres_reg[31:0];
                            k_reg    <= '0;
                            st_reg   <= S_DIV;
                        end
                    end else begin
                        if (sx_reg >= sres_reg + sbit_reg) begin
                            sx_reg   <= sx_reg - (sres_reg + sbit_reg);
                            sres_reg <= (sres_reg >> 1) + sbit_reg;
                        end else sres_reg <= sres_reg >> 1;
                        sbit_reg <= sbit_reg >> 2;
                    end
                end
                S_DIV: begin
                    ma_reg <= $signed({1'b0, vabs[30:0]});
                    mb_reg <= br_reg;
                    st_reg <= S_DIVW;
                    dcnt_reg <= 7'd0;
                end
                S_DIVW: begin
                    if (dcnt_reg == 7'd0) begin
                        dnum_reg <= vabs[31] ? (64'($unsigned(br_reg)) << 31)
                                             : $unsigned(mp);
                        drem_reg <= '0;
                        dquo_reg <= '0;
                        dcnt_reg <= 7'd1;
                    end else if (dcnt_reg <= 7'd64) begin
                        logic [64:0] r2;
                        r2 = {drem_reg, dnum_reg[64 - 32'(dcnt_reg)]};
                        if (r2 >= 65'(dden_reg)) begin
                            drem_reg <= 64'(r2 - 65'(dden_reg));
                            dquo_reg <= {dquo_reg[62:0], 1'b1};
                        end else begin
                            drem_reg <= r2[63:0];
                            dquo_reg <= {dquo_reg[62:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg + 7'd1;
                    end else begin
                        c_reg[k_reg] <= vk[31]
                                      ? sat32(-$signed(dquo_reg)) : sat32($signed(dquo_reg));
                        if (k_reg == 2'd2) begin
                            k_reg   <= '0;
                            t_reg   <= '0;
                            acc_reg <= '0;
                            prod_reg <= '0;
                            st_reg  <= S_E1;
                        end else begin
                            k_reg  <= k_reg + 2'd1;
                            st_reg <= S_DIV;
                        end
                    end
                end
                // k 0: e1, k 1: e2
                S_E1: begin
                    ma_reg <= (k_reg == 2'd0)
                        ? sat32(64'(vsel(cen_reg, t_reg)) + 64'(vsel(c_reg, t_reg)))
                        : sat32(64'(vsel(cen_reg, t_reg)) - 64'(vsel(c_reg, t_reg)));
                    mb_reg <= vsel(nrm, t_reg);
                    st_reg <= S_E1W;
                end
                S_E1W: begin
                    if (t_reg == 2'd2) begin
                        t_reg   <= '0;
                        acc_reg <= '0;
                        if (acc_reg + qshift(mp) - 64'(off) >= 0) st_reg <= S_E2W;
                        else if (k_reg == 2'd0) begin
                            k_reg  <= 2'd1;
                            st_reg <= S_E1;
                        end else begin
                            vis_reg <= 1'b0;
                            st_reg  <= S_OUT;
                        end
                    end else begin
                        acc_reg <= acc_reg + qshift(mp);
                        t_reg   <= t_reg + 2'd1;
                        st_reg  <= S_E1;
                    end
                end
                // plane did not cull: advance
                S_E2W: begin
                    t_reg   <= '0;
                    k_reg   <= '0;
                    acc_reg <= '0;
                    if (last_pl) begin
                        vis_reg <= 1'b1;
                        st_reg  <= S_OUT;
                    end else begin
                        pl_reg <= pl_reg + 1'b1;
                        st_reg <= S_TIP;
                    end
                end
                S_OUT: begin
                    if (!res_v_reg || res_ready) begin
                        res_v_reg    <= 1'b1;
                        out_vis_reg  <= vis_reg;
                        out_kind_reg <= job_reg.spot;
                        st_reg       <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
            if (res_v_reg && res_ready && !(st_reg == S_OUT)) res_v_reg <= 1'b0;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_OUT && res_v_reg && !res_ready) |=> (st_reg == S_OUT))
        else $error("result overwritten");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> res_valid) else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        job_ready |-> !(st_reg == S_OUT)) else $error("ready while busy");

endmodule
